// ===== hdl/bf7_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf7_pkg
// Shared types and constants for the 7x7 box filter.
// ----------------------------------------------------------------------------
package bf7_pkg;

   localparam int unsigned MAX_COLS_DEFAULT = 512;
   localparam int unsigned IMG_DIM_RESET    = 512;

   localparam int unsigned PIX_W  = 8;
   localparam int unsigned COL_W  = 10;
   localparam int unsigned ROW_W  = 10;
   localparam int unsigned CNT_W  = 20;   // holds up to 1023 * 1023
   localparam int unsigned WIN    = 7;
   localparam int unsigned HIST   = 6;
   localparam int unsigned HALF   = 3;
   localparam int unsigned CSUM_W = 11;   // 7 * 255
   localparam int unsigned SUM_W  = 14;   // 49 * 255 + 24

   // floor(x / 49) = (x * 21400) >> 20 for x below 2^14
   localparam int unsigned ROUND_BIAS = 24;
   localparam int unsigned DIV_MUL    = 21400;
   localparam int unsigned DIV_SHIFT  = 20;
   localparam int unsigned PROD_W     = 28;

   localparam int unsigned APB_ADDR_W  = 3;
   localparam int unsigned APB_DATA_W  = 32;
   localparam int unsigned REG_IDX_LSB = 2;

   typedef enum logic [0:0] {
      REG_COLS = 1'b0,
      REG_ROWS = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic push;    // shifts a pixel into the line store and window
      logic emit;    // produces an output transaction
      logic last;    // final output of the image
      logic inter;   // output lies inside the three-pixel border
   } stage_ctl_type;

   function automatic logic [COL_W-1:0] clamp_cols(input logic [COL_W-1:0] raw,
                                                   input logic [COL_W-1:0] cap);
      logic [COL_W-1:0] val;
      val = raw;
      if (val < COL_W'(WIN)) begin
         val = COL_W'(WIN);
      end
      if (val > cap) begin
         val = cap;
      end
      return val;
   endfunction

   function automatic logic [ROW_W-1:0] clamp_rows(input logic [ROW_W-1:0] raw);
      return (raw < ROW_W'(WIN)) ? ROW_W'(WIN) : raw;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/bf7_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf7_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bf7_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/box_filter_7x7_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_7x7_top
// 7x7 mean filter over a raster-order 8-bit greyscale stream.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  req      | in        | req_valid/ready  | req_kind, req_pixel
//  rsp      | out       | rsp_valid/ready  | rsp_smoothed, rsp_last
//  csr      | in        | APB psel/penable | image_cols @ 0x0, image_rows @ 0x4
//
//  One transaction per cycle while rsp is not stalled. A result passes through
//  a five-register pipeline (line RAM read, column sum, box sum, reciprocal
//  multiply, output register).
//  Synchronous reset clears the counters and sets a 512 x 512 image; the line
//  RAM is not cleared. A stalled rsp holds only the stages behind it that are
//  full; empty stages keep taking transactions.
// ----------------------------------------------------------------------------
module box_filter_7x7_top
   import bf7_pkg::*;
#(
   parameter int unsigned MAX_COLS = MAX_COLS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output logic      [APB_DATA_W-1:0] prdata,
   output logic                       pready,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_kind,
   input  wire logic [PIX_W-1:0]      req_pixel,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [PIX_W-1:0]      rsp_smoothed,
   output logic                       rsp_last
);

   localparam int unsigned ADDR_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned COL_CAP      = (MAX_COLS < 1023) ? MAX_COLS : 1023;
   localparam int unsigned RST_COLS     = (IMG_DIM_RESET > COL_CAP) ? COL_CAP
                                                                    : IMG_DIM_RESET;
   localparam int unsigned RST_TOTAL    = RST_COLS * IMG_DIM_RESET;
   localparam int unsigned LINE_W       = HIST * PIX_W;

   // configuration
   logic                 csr_wr;
   reg_index_type        reg_sel;
   logic [COL_W-1:0]     cols_raw_ff, cols_raw_in;
   logic [ROW_W-1:0]     rows_raw_ff, rows_raw_in;
   logic [COL_W-1:0]     cols_eff_ff, cols_eff_in;
   logic [ROW_W-1:0]     rows_eff_ff, rows_eff_in;
   logic [CNT_W-1:0]     total_ff, total_in;

   // position counters
   logic [COL_W-1:0]     in_col_ff, in_col_in;
   logic [ROW_W-1:0]     in_row_ff, in_row_in;
   logic [CNT_W-1:0]     out_cnt_ff, out_cnt_in;

   logic                 accept;
   logic                 drain;
   logic                 has_left;
   logic                 hit_last;
   logic                 produce;
   logic                 inter;
   logic                 col_wrap;
   logic                 restart;
   stage_ctl_type        ctl;

   // pipeline
   logic                 a_go, b_go, c_go, d_go;
   logic                 a_v_ff, a_v_in;
   logic                 b_v_ff, c_v_ff, d_v_ff;
   stage_ctl_type        a_ctl_ff, b_ctl_ff, c_ctl_ff, d_ctl_ff;
   logic [PIX_W-1:0]     a_pixel_ff;
   logic [ADDR_W-1:0]    a_col_ff;
   logic [LINE_W-1:0]    line_rd;
   logic [LINE_W-1:0]    line_wr;
   logic                 line_we;
   logic [CSUM_W-1:0]    col_sum;
   logic [CSUM_W-1:0]    cs_ff [WIN];
   logic [SUM_W-1:0]     box_sum;
   logic [SUM_W-1:0]     c_x_ff;
   logic [PROD_W-1:0]    d_prod_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;

   // ---------------------------------------------------------------- csr
   assign csr_wr  = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[REG_IDX_LSB]);

   always_comb begin
      unique case (reg_sel)
         REG_COLS: prdata = {{(APB_DATA_W-COL_W){1'b0}}, cols_raw_ff};
         REG_ROWS: prdata = {{(APB_DATA_W-ROW_W){1'b0}}, rows_raw_ff};
         default:  prdata = '0;
      endcase
   end

   always_comb begin
      cols_raw_in = cols_raw_ff;
      rows_raw_in = rows_raw_ff;
      cols_eff_in = cols_eff_ff;
      rows_eff_in = rows_eff_ff;
      if (csr_wr) begin
         unique case (reg_sel)
            REG_COLS: begin
               cols_raw_in = pwdata[COL_W-1:0];
               cols_eff_in = clamp_cols(pwdata[COL_W-1:0], COL_W'(COL_CAP));
            end
            REG_ROWS: begin
               rows_raw_in = pwdata[ROW_W-1:0];
               rows_eff_in = clamp_rows(pwdata[ROW_W-1:0]);
            end
            default: begin
               cols_raw_in = cols_raw_ff;
            end
         endcase
      end
      total_in = {{(CNT_W-COL_W){1'b0}}, cols_eff_in}
               * {{(CNT_W-ROW_W){1'b0}}, rows_eff_in};
   end

   // ---------------------------------------------------------- counters
   assign accept   = req_valid & req_ready;
   assign drain    = in_row_ff >= rows_eff_ff;
   assign has_left = out_cnt_ff < total_ff;
   assign hit_last = CNT_W'(out_cnt_ff + CNT_W'(1)) == total_ff;
   assign produce  = (in_row_ff > ROW_W'(HALF))
                  || ((in_row_ff == ROW_W'(HALF)) && (in_col_ff >= COL_W'(HALF)));
   assign inter    = (in_row_ff >= ROW_W'(2 * HALF)) && (in_col_ff >= COL_W'(2 * HALF));
   assign col_wrap = COL_W'(in_col_ff + COL_W'(1)) >= cols_eff_ff;

   always_comb begin
      ctl     = '0;
      restart = 1'b0;
      priority if (drain) begin
         if (has_left) begin
            ctl.emit = 1'b1;
            ctl.last = hit_last;
            restart  = hit_last;
         end else begin
            restart  = 1'b1;
         end
      end else if (!req_kind) begin
         ctl.push  = 1'b1;
         ctl.inter = inter;
         ctl.emit  = produce & has_left;
         ctl.last  = produce & has_left & hit_last;
         restart   = produce & has_left & hit_last;
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_cnt_in = out_cnt_ff;
      if (csr_wr) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_cnt_in = '0;
      end else if (accept) begin
         if (ctl.push) begin
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = ROW_W'(in_row_ff + ROW_W'(1));
            end else begin
               in_col_in = COL_W'(in_col_ff + COL_W'(1));
            end
         end
         if (ctl.emit) begin
            out_cnt_in = CNT_W'(out_cnt_ff + CNT_W'(1));
         end
         if (restart) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_cnt_in = '0;
         end
      end
   end

   // ---------------------------------------------------------- pipeline
   assign d_go      = !d_v_ff || !d_ctl_ff.emit || !rsp_valid_ff || rsp_ready;
   assign c_go      = !c_v_ff || d_go;
   assign b_go      = !b_v_ff || c_go;
   assign a_go      = !a_v_ff || b_go;
   assign req_ready = a_go;
   assign a_v_in    = accept & (ctl.push | ctl.emit);

   bf7_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (a_col_ff),
      .wr_data (line_wr),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(in_col_ff)),
      .rd_data (line_rd)
   );

   // oldest row in the low byte; the new pixel enters at the top
   assign line_wr = {a_pixel_ff, line_rd[LINE_W-1:PIX_W]};
   assign line_we = a_v_ff & b_go & a_ctl_ff.push;

   always_comb begin
      col_sum = CSUM_W'(a_pixel_ff);
      for (int k = 0; k < HIST; k++) begin
         col_sum = CSUM_W'(col_sum + CSUM_W'(line_rd[k*PIX_W +: PIX_W]));
      end
   end

   always_comb begin
      box_sum = SUM_W'(ROUND_BIAS);
      for (int k = 0; k < WIN; k++) begin
         box_sum = SUM_W'(box_sum + SUM_W'(cs_ff[k]));
      end
   end

   assign rsp_load = d_v_ff & d_ctl_ff.emit & d_go;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // -------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_raw_ff  <= COL_W'(IMG_DIM_RESET);
         rows_raw_ff  <= ROW_W'(IMG_DIM_RESET);
         cols_eff_ff  <= COL_W'(RST_COLS);
         rows_eff_ff  <= ROW_W'(IMG_DIM_RESET);
         total_ff     <= CNT_W'(RST_TOTAL);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_cnt_ff   <= '0;
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         d_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cols_raw_ff  <= cols_raw_in;
         rows_raw_ff  <= rows_raw_in;
         cols_eff_ff  <= cols_eff_in;
         rows_eff_ff  <= rows_eff_in;
         total_ff     <= total_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_cnt_ff   <= out_cnt_in;
         if (a_go) begin
            a_v_ff <= a_v_in;
         end
         if (b_go) begin
            b_v_ff <= a_v_ff;
         end
         if (c_go) begin
            c_v_ff <= b_v_ff;
         end
         if (d_go) begin
            d_v_ff <= c_v_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // -------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (a_go) begin
         a_ctl_ff   <= ctl;
         a_pixel_ff <= req_pixel;
         a_col_ff   <= ADDR_W'(in_col_ff);
      end
      if (line_we) begin
         for (int k = 0; k < WIN - 1; k++) begin
            cs_ff[k] <= cs_ff[k+1];
         end
         cs_ff[WIN-1] <= col_sum;
      end
      if (b_go) begin
         b_ctl_ff <= a_ctl_ff;
      end
      if (c_go) begin
         c_ctl_ff <= b_ctl_ff;
         c_x_ff   <= box_sum;
      end
      if (d_go) begin
         d_ctl_ff  <= c_ctl_ff;
         d_prod_ff <= {{(PROD_W-SUM_W){1'b0}}, c_x_ff} * PROD_W'(DIV_MUL);
      end
      if (rsp_load) begin
         rsp_smoothed <= d_ctl_ff.inter ? d_prod_ff[DIV_SHIFT +: PIX_W] : '0;
         rsp_last     <= d_ctl_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // -------------------------------------------------------- assertions
   assert property (@(posedge clock) disable iff (reset) in_col_ff < cols_eff_ff)
      else $error("column counter beyond image width");

   assert property (@(posedge clock) disable iff (reset) out_cnt_ff < total_ff)
      else $error("output count reached image size without restart");

   assert property (@(posedge clock) disable iff (reset)
                    (b_v_ff && b_ctl_ff.inter) |-> b_ctl_ff.push)
      else $error("interior output without a pixel shift");

   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && req_ready && drain) |=> (a_v_ff && !a_ctl_ff.push)
                                                        || !a_v_ff)
      else $error("drain transaction wrote the line store");

endmodule
`default_nettype wire
